FILE: design/tttu_pkg.sv
package tttu_pkg;

   localparam logic [2:0] CMD_CREATE         = 3'd0;
   localparam logic [2:0] CMD_STATUS_BY_ID   = 3'd1;
   localparam logic [2:0] CMD_ERROR_BY_ID    = 3'd2;
   localparam logic [2:0] CMD_ASSIGN_TRANS   = 3'd3;
   localparam logic [2:0] CMD_STATUS_BY_TRANS = 3'd4;
   localparam logic [2:0] CMD_ERROR_BY_TRANS = 3'd5;

   localparam logic [3:0] STATUS_TRANS_ASSIGNED = 4'd1;
   localparam logic [3:0] STATUS_DATA_CONFIRM   = 4'd2;
   localparam logic [3:0] STATUS_CLOSED_OK      = 4'd3;
   localparam logic [3:0] STATUS_CLOSED_ERR     = 4'd4;

   localparam logic [3:0] ERR_NONE      = 4'd0;
   localparam logic [3:0] ERR_DUP_ID    = 4'd1;
   localparam logic [3:0] ERR_DUP_TRANS = 4'd2;

   typedef struct packed {
      logic [2:0]  command;
      logic [31:0] msg_id;
      logic [7:0]  txn_id;
      logic [3:0]  status_code;
      logic [3:0]  error_code;
   } req_item_type;

   typedef struct packed {
      logic        result_code;
      logic [31:0] duplicate_id_count;
      logic [31:0] reused_trans_count;
   } rsp_item_type;

   // Everything in a table entry except the age stamp, whose width is a parameter.
   typedef struct packed {
      logic [31:0] msg_id;
      logic [3:0]  status;
      logic [3:0]  error;
      logic [7:0]  txn_id;
      logic        trans_valid;
      logic        running;
   } entry_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_WRITE
   } fsm_type;

   function automatic entry_type apply_error(input entry_type e, input logic [3:0] err);
      entry_type r;
      r = e;
      r.error = err;
      if (err != ERR_NONE && e.status != STATUS_CLOSED_ERR) begin
         r.status = STATUS_CLOSED_ERR;
         r.trans_valid = 1'b0;
         r.running = 1'b0;
      end
      return r;
   endfunction

endpackage

FILE: design/tx_transaction_tracking_table_unit.sv
// Every command rotates the whole ring of ENTRIES cells once past the head cell
// before its result is shown; create takes two rotations (search, then write)
// and shows its result after the second.
// A new command is accepted in the cycle the result strobe is high.
// Synchronous reset clears all entries, the age counter and both counters.
// The result is shown for one cycle; the receiver cannot stall it.
module tx_transaction_tracking_table_unit #(
   parameter int ENTRIES  = 128,
   parameter int AGE_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  tttu_pkg::req_item_type req_data,
   output logic                   rsp_valid,
   output tttu_pkg::rsp_item_type rsp_data
);
   import tttu_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   entry_type           cell_entry [ENTRIES];
   logic [AGE_BITS-1:0] cell_age [ENTRIES];
   entry_type           head_new;
   logic [AGE_BITS-1:0] head_age_new;
   logic                shift_en;

   fsm_type             state_ff, state_in;
   req_item_type        req_ff, req_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic                found_ff, found_in;
   logic [IDX_W-1:0]    sel_ff, sel_in;
   logic [IDX_W-1:0]    oldest_ff, oldest_in;
   logic [AGE_BITS-1:0] max_age_ff, max_age_in;
   logic [AGE_BITS-1:0] age_cnt_ff, age_cnt_in;
   logic [31:0]         dup_cnt_ff, dup_cnt_in;
   logic [31:0]         reuse_cnt_ff, reuse_cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_item_type        rsp_ff, rsp_in;

   assign shift_en = (state_ff != FSM_IDLE);

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      tttu_cell #(.AGE_BITS(AGE_BITS)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift_en  (shift_en),
         .entry_in  ((i == ENTRIES - 1) ? head_new : cell_entry[(i + 1) % ENTRIES]),
         .age_in    ((i == ENTRIES - 1) ? head_age_new : cell_age[(i + 1) % ENTRIES]),
         .entry_out (cell_entry[i]),
         .age_out   (cell_age[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         idx_ff       <= '0;
         found_ff     <= 1'b0;
         age_cnt_ff   <= '0;
         dup_cnt_ff   <= '0;
         reuse_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         found_ff     <= found_in;
         age_cnt_ff   <= age_cnt_in;
         dup_cnt_ff   <= dup_cnt_in;
         reuse_cnt_ff <= reuse_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff     <= req_in;
      sel_ff     <= sel_in;
      oldest_ff  <= oldest_in;
      max_age_ff <= max_age_in;
      rsp_ff     <= rsp_in;
   end

   always_comb begin
      entry_type           h;
      logic [AGE_BITS-1:0] h_age;
      logic                last;
      h            = cell_entry[0];
      h_age        = age_cnt_ff - cell_age[0];
      last         = (idx_ff == LAST_IDX);
      head_new     = cell_entry[0];
      head_age_new = cell_age[0];
      state_in     = state_ff;
      req_in       = req_ff;
      idx_in       = idx_ff;
      found_in     = found_ff;
      sel_in       = sel_ff;
      oldest_in    = oldest_ff;
      max_age_in   = max_age_ff;
      age_cnt_in   = age_cnt_ff;
      dup_cnt_in   = dup_cnt_ff;
      reuse_cnt_in = reuse_cnt_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      case (state_ff)
         FSM_IDLE: begin
            if (start) begin
               req_in     = req_data;
               state_in   = FSM_SCAN;
               idx_in     = '0;
               found_in   = 1'b0;
               sel_in     = '0;
               oldest_in  = '0;
               max_age_in = '0;
            end
         end
         FSM_SCAN: begin
            case (req_ff.command)
               CMD_CREATE: begin
                  // The first free or same-id entry wins; otherwise the oldest.
                  if (!found_ff) begin
                     if (!h.running || h.msg_id == req_ff.msg_id) begin
                        found_in = 1'b1;
                        sel_in   = idx_ff;
                     end else if (h_age > max_age_ff) begin
                        max_age_in = h_age;
                        oldest_in  = idx_ff;
                     end
                  end
               end
               CMD_STATUS_BY_ID, CMD_ERROR_BY_ID: begin
                  if (!found_ff && h.msg_id == req_ff.msg_id) begin
                     found_in = 1'b1;
                     if (req_ff.command == CMD_STATUS_BY_ID) begin
                        head_new.status = req_ff.status_code;
                     end else begin
                        head_new = apply_error(h, req_ff.error_code);
                     end
                  end
               end
               CMD_ASSIGN_TRANS: begin
                  if (h.running) begin
                     if (h.msg_id == req_ff.msg_id) begin
                        if (!found_ff) begin
                           found_in = 1'b1;
                           if (h.trans_valid) begin
                              reuse_cnt_in = reuse_cnt_ff + 32'd1;
                           end
                           head_new.trans_valid = 1'b1;
                           head_new.txn_id      = req_ff.txn_id;
                           head_new.status      = STATUS_TRANS_ASSIGNED;
                        end else begin
                           dup_cnt_in       = dup_cnt_ff + 32'd1;
                           head_new         = apply_error(h, ERR_DUP_ID);
                           head_new.running = 1'b0;
                        end
                     end else if (h.trans_valid && h.txn_id == req_ff.txn_id) begin
                        head_new             = apply_error(h, ERR_DUP_TRANS);
                        head_new.trans_valid = 1'b0;
                        head_new.running     = 1'b0;
                     end
                  end
               end
               CMD_STATUS_BY_TRANS, CMD_ERROR_BY_TRANS: begin
                  if (h.running && h.trans_valid && h.txn_id == req_ff.txn_id) begin
                     found_in = 1'b1;
                     if (req_ff.command == CMD_STATUS_BY_TRANS) begin
                        head_new.status = req_ff.status_code;
                        if (req_ff.status_code == STATUS_DATA_CONFIRM) begin
                           head_new.trans_valid = 1'b0;
                           head_new.status      = STATUS_CLOSED_OK;
                           head_new.running     = 1'b0;
                        end
                     end else begin
                        head_new = apply_error(h, req_ff.error_code);
                     end
                  end
               end
               default: begin
               end
            endcase
            idx_in = idx_ff + IDX_W'(1);
            if (last) begin
               idx_in = '0;
               if (req_ff.command == CMD_CREATE) begin
                  state_in = FSM_WRITE;
                  if (!found_in) begin
                     sel_in = oldest_in;
                  end
               end else begin
                  state_in     = FSM_IDLE;
                  rsp_valid_in = 1'b1;
                  rsp_in.result_code = !found_in &&
                     (req_ff.command == CMD_STATUS_BY_ID ||
                      req_ff.command == CMD_ERROR_BY_ID ||
                      req_ff.command == CMD_ASSIGN_TRANS ||
                      req_ff.command == CMD_STATUS_BY_TRANS ||
                      req_ff.command == CMD_ERROR_BY_TRANS);
                  rsp_in.duplicate_id_count = dup_cnt_in;
                  rsp_in.reused_trans_count = reuse_cnt_in;
               end
            end
         end
         FSM_WRITE: begin
            if (idx_ff == sel_ff) begin
               head_new.msg_id      = req_ff.msg_id;
               head_new.status      = req_ff.status_code;
               head_new.error       = ERR_NONE;
               head_new.txn_id      = '0;
               head_new.trans_valid = 1'b0;
               head_new.running     = 1'b1;
               head_age_new         = age_cnt_ff;
            end
            idx_in = idx_ff + IDX_W'(1);
            if (last) begin
               idx_in       = '0;
               state_in     = FSM_IDLE;
               age_cnt_in   = age_cnt_ff + AGE_BITS'(1);
               rsp_valid_in = 1'b1;
               rsp_in.result_code        = 1'b0;
               rsp_in.duplicate_id_count = dup_cnt_ff;
               rsp_in.reused_trans_count = reuse_cnt_ff;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != FSM_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_fall_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(busy) |-> rsp_valid)
      else $error("command finished without a result");
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while a scan is still running");
   a_idx_idle: assert property (@(posedge clock) disable iff (reset)
      !busy |-> idx_ff == '0)
      else $error("ring position lost between commands");
`endif

endmodule

FILE: design/tttu_cell.sv
module tttu_cell #(
   parameter int AGE_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     shift_en,
   input  tttu_pkg::entry_type      entry_in,
   input  logic [AGE_BITS-1:0]      age_in,
   output tttu_pkg::entry_type      entry_out,
   output logic [AGE_BITS-1:0]      age_out
);
   import tttu_pkg::*;

   entry_type           entry_ff;
   logic [AGE_BITS-1:0] age_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
         age_ff   <= '0;
      end else if (shift_en) begin
         entry_ff <= entry_in;
         age_ff   <= age_in;
      end
   end

   assign entry_out = entry_ff;
   assign age_out   = age_ff;

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import tttu_pkg::*;

   localparam int SLOTS = 128;
   localparam int RANDOM_ITEMS = 1400;
   localparam int IDLE_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 2 * SLOTS + 20;
   localparam logic [2:0] CMD_SPARE_6 = 3'd6;
   localparam logic [2:0] CMD_SPARE_7 = 3'd7;

   typedef struct {
      req_item_type req;
      bit           typed;
      rsp_item_type want;
   } stim_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_item_type req_data = '0;
   logic         rsp_valid;
   rsp_item_type rsp_data;

   // Shadow copy of the tracking table.
   logic [31:0] slot_id [SLOTS];
   logic [31:0] slot_stamp [SLOTS];
   logic [3:0]  slot_status [SLOTS];
   logic [3:0]  slot_error [SLOTS];
   logic [7:0]  slot_tid [SLOTS];
   logic        slot_tid_valid [SLOTS];
   logic        slot_running [SLOTS];
   logic [31:0] age_now;
   logic [31:0] dup_ids;
   logic [31:0] reused_tids;

   rsp_item_type pending_rsp [$];
   stim_row_type directed [$];
   int           mismatches = 0;
   int           idle_cycles = 0;
   int           burst_left = 0;
   bit           item_taken;

   tx_transaction_tracking_table_unit uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
      mismatches++;
   endtask

   function automatic void clear_table();
      for (int k = 0; k < SLOTS; k++) begin
         slot_id[k] = '0;
         slot_stamp[k] = '0;
         slot_status[k] = '0;
         slot_error[k] = '0;
         slot_tid[k] = '0;
         slot_tid_valid[k] = 1'b0;
         slot_running[k] = 1'b0;
      end
      age_now = '0;
      dup_ids = '0;
      reused_tids = '0;
   endfunction

   function automatic void close_with_error(input int k, input logic [3:0] err);
      slot_error[k] = err;
      if (err != ERR_NONE && slot_status[k] != STATUS_CLOSED_ERR) begin
         slot_status[k] = STATUS_CLOSED_ERR;
         slot_tid_valid[k] = 1'b0;
         slot_running[k] = 1'b0;
      end
   endfunction

   // Applies one command to the shadow table and returns the result it gives.
   function automatic rsp_item_type track_command(input req_item_type r);
      rsp_item_type o;
      int           hit;
      int           oldest;
      logic [31:0]  oldest_age;
      bit           found;
      o = '0;
      hit = SLOTS;
      found = 1'b0;
      case (r.command)
         CMD_CREATE: begin
            oldest = 0;
            oldest_age = age_now - slot_stamp[0];
            for (int k = 0; k < SLOTS; k++) begin
               if (!slot_running[k] || slot_id[k] == r.msg_id) begin
                  hit = k;
                  break;
               end
               if (age_now - slot_stamp[k] > oldest_age) begin
                  oldest_age = age_now - slot_stamp[k];
                  oldest = k;
               end
            end
            if (hit == SLOTS) hit = oldest;
            slot_id[hit] = r.msg_id;
            slot_stamp[hit] = age_now;
            age_now = age_now + 1;
            slot_status[hit] = r.status_code;
            slot_error[hit] = ERR_NONE;
            slot_tid[hit] = '0;
            slot_tid_valid[hit] = 1'b0;
            slot_running[hit] = 1'b1;
         end
         CMD_STATUS_BY_ID, CMD_ERROR_BY_ID: begin
            for (int k = 0; k < SLOTS; k++)
               if (slot_id[k] == r.msg_id) begin
                  hit = k;
                  break;
               end
            if (hit == SLOTS) o.result_code = 1'b1;
            else if (r.command == CMD_STATUS_BY_ID) slot_status[hit] = r.status_code;
            else close_with_error(hit, r.error_code);
         end
         CMD_ASSIGN_TRANS: begin
            for (int k = 0; k < SLOTS; k++) begin
               if (!slot_running[k]) continue;
               if (slot_id[k] == r.msg_id) begin
                  if (!found) begin
                     found = 1'b1;
                     if (slot_tid_valid[k]) reused_tids++;
                     else slot_tid_valid[k] = 1'b1;
                     slot_tid[k] = r.txn_id;
                     slot_status[k] = STATUS_TRANS_ASSIGNED;
                  end else begin
                     dup_ids++;
                     close_with_error(k, ERR_DUP_ID);
                     slot_running[k] = 1'b0;
                  end
               end else if (slot_tid_valid[k] && slot_tid[k] == r.txn_id) begin
                  close_with_error(k, ERR_DUP_TRANS);
                  slot_tid_valid[k] = 1'b0;
                  slot_running[k] = 1'b0;
               end
            end
            o.result_code = !found;
         end
         CMD_STATUS_BY_TRANS, CMD_ERROR_BY_TRANS: begin
            for (int k = 0; k < SLOTS; k++) begin
               if (!(slot_running[k] && slot_tid_valid[k] && slot_tid[k] == r.txn_id))
                  continue;
               found = 1'b1;
               if (r.command == CMD_STATUS_BY_TRANS) begin
                  slot_status[k] = r.status_code;
                  if (r.status_code == STATUS_DATA_CONFIRM) begin
                     slot_tid_valid[k] = 1'b0;
                     slot_status[k] = STATUS_CLOSED_OK;
                     slot_running[k] = 1'b0;
                  end
               end else begin
                  close_with_error(k, r.error_code);
               end
            end
            o.result_code = !found;
         end
         default: ;
      endcase
      o.duplicate_id_count = dup_ids;
      o.reused_trans_count = reused_tids;
      return o;
   endfunction

   function automatic void add_row(input logic [2:0] cmd, input logic [31:0] id,
                                   input logic [7:0] tid, input logic [3:0] st,
                                   input logic [3:0] er, input bit typed,
                                   input logic rc, input logic [31:0] dups,
                                   input logic [31:0] reuses);
      stim_row_type row;
      row.req = '{command: cmd, msg_id: id, txn_id: tid, status_code: st,
                  error_code: er};
      row.typed = typed;
      row.want = '{result_code: rc, duplicate_id_count: dups, reused_trans_count: reuses};
      directed.push_back(row);
   endfunction

   function automatic req_item_type random_item();
      req_item_type r;
      int           pick;
      pick = $urandom_range(0, 99);
      if (pick < 35) r.command = CMD_CREATE;
      else if (pick < 45) r.command = CMD_STATUS_BY_ID;
      else if (pick < 53) r.command = CMD_ERROR_BY_ID;
      else if (pick < 73) r.command = CMD_ASSIGN_TRANS;
      else if (pick < 85) r.command = CMD_STATUS_BY_TRANS;
      else if (pick < 96) r.command = CMD_ERROR_BY_TRANS;
      else r.command = pick[0] ? CMD_SPARE_7 : CMD_SPARE_6;
      // A small id pool makes hits, duplicates and a full table likely.
      pick = $urandom_range(0, 99);
      if (pick < 85) r.msg_id = $urandom_range(1, 180);
      else if (pick < 90) r.msg_id = '0;
      else r.msg_id = $urandom;
      r.txn_id = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 15)) : 8'($urandom);
      r.status_code = ($urandom_range(0, 2) == 0) ? STATUS_DATA_CONFIRM : 4'($urandom);
      pick = $urandom_range(0, 9);
      if (pick < 3) r.error_code = ERR_NONE;
      else if (pick < 5) r.error_code = ERR_DUP_ID;
      else if (pick < 6) r.error_code = ERR_DUP_TRANS;
      else r.error_code = 4'($urandom);
      return r;
   endfunction

   // Holds the item on the ports until the block takes it, then records the
   // expected result. A random gap may come before the item.
   task automatic send_item(input req_item_type r, input bit typed,
                            input rsp_item_type want);
      rsp_item_type predicted;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         if ($urandom_range(0, 3) != 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
      burst_left--;
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      predicted = track_command(r);
      pending_rsp.push_back(typed ? want : predicted);
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected result", 32'(rsp_data.result_code), '0);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.result_code !== want.result_code)
               report_mismatch("result_code", 32'(rsp_data.result_code),
                               32'(want.result_code));
            if (rsp_data.duplicate_id_count !== want.duplicate_id_count)
               report_mismatch("duplicate_id_count", rsp_data.duplicate_id_count,
                               want.duplicate_id_count);
            if (rsp_data.reused_trans_count !== want.reused_trans_count)
               report_mismatch("reused_trans_count", rsp_data.reused_trans_count,
                               want.reused_trans_count);
         end
      end
   end

   // Watchdog on cycles where neither an item nor a result moves.
   always @(posedge clock) begin
      item_taken = start && !busy;
      if (reset || item_taken || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      clear_table();
      // Fresh table: every slot holds id zero and nothing runs.
      add_row(CMD_STATUS_BY_ID, 32'h5, 8'h0, 4'h0, ERR_NONE, 1, 1'b1, 0, 0);
      add_row(CMD_STATUS_BY_ID, 32'h0, 8'h0, 4'h0, ERR_NONE, 1, 1'b0, 0, 0);
      add_row(CMD_ASSIGN_TRANS, 32'h0, 8'h0, 4'h0, ERR_NONE, 1, 1'b1, 0, 0);
      add_row(CMD_SPARE_6, 32'hFFFFFFFF, 8'hFF, 4'hF, 4'hF, 1, 1'b0, 0, 0);
      add_row(CMD_SPARE_7, 32'h0, 8'h0, 4'h0, ERR_NONE, 1, 1'b0, 0, 0);
      add_row(CMD_STATUS_BY_TRANS, 32'h0, 8'h0, STATUS_DATA_CONFIRM, ERR_NONE, 1, 1'b1, 0, 0);
      add_row(CMD_ERROR_BY_TRANS, 32'h0, 8'hFF, 4'h0, 4'hF, 1, 1'b1, 0, 0);
      add_row(CMD_CREATE, 32'hFFFFFFFF, 8'h0, 4'h0, ERR_NONE, 1, 1'b0, 0, 0);
      add_row(CMD_CREATE, 32'hFFFFFFFF, 8'h0, 4'hF, ERR_NONE, 1, 1'b0, 0, 0);
      add_row(CMD_ASSIGN_TRANS, 32'hFFFFFFFF, 8'hFF, 4'h0, ERR_NONE, 1, 1'b0, 0, 0);
      add_row(CMD_ASSIGN_TRANS, 32'hFFFFFFFF, 8'h5A, 4'h0, ERR_NONE, 1, 1'b0, 0, 1);
      // Build a duplicate id behind a freed slot, then a clashing trans id.
      add_row(CMD_CREATE, 32'hA, 8'h0, 4'h0, ERR_NONE, 0, 0, 0, 0);
      add_row(CMD_CREATE, 32'hB, 8'h0, 4'h0, ERR_NONE, 0, 0, 0, 0);
      add_row(CMD_ERROR_BY_ID, 32'hA, 8'h0, 4'h0, 4'h3, 0, 0, 0, 0);
      add_row(CMD_ERROR_BY_ID, 32'hA, 8'h0, 4'h0, 4'h7, 0, 0, 0, 0);
      add_row(CMD_CREATE, 32'hB, 8'h0, 4'h0, ERR_NONE, 0, 0, 0, 0);
      add_row(CMD_ASSIGN_TRANS, 32'hB, 8'h5A, 4'h0, ERR_NONE, 0, 0, 0, 0);
      add_row(CMD_ERROR_BY_ID, 32'hB, 8'h0, 4'h0, ERR_NONE, 0, 0, 0, 0);
      add_row(CMD_CREATE, 32'hC, 8'h0, 4'h0, ERR_NONE, 0, 0, 0, 0);
      add_row(CMD_ASSIGN_TRANS, 32'hC, 8'h5A, 4'h0, ERR_NONE, 0, 0, 0, 0);
      add_row(CMD_STATUS_BY_TRANS, 32'h0, 8'h5A, 4'h9, ERR_NONE, 0, 0, 0, 0);
      add_row(CMD_STATUS_BY_TRANS, 32'h0, 8'h5A, STATUS_DATA_CONFIRM, ERR_NONE, 0, 0, 0, 0);
      add_row(CMD_ERROR_BY_TRANS, 32'h0, 8'h5A, 4'h0, ERR_DUP_TRANS, 0, 0, 0, 0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      foreach (directed[i]) send_item(directed[i].req, directed[i].typed, directed[i].want);
      for (int i = 0; i < RANDOM_ITEMS; i++) send_item(random_item(), 0, '0);
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
